// ===== hdl/integer_alu_gcd_lcm_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer ALU with GCD and LCM
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ALU_GCD_LCM_MACROS_SVH
`define INTEGER_ALU_GCD_LCM_MACROS_SVH

// Same-cycle implication
`define IALU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg
// Operation codes and default widths for the integer ALU with GCD and LCM.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int OP_W           = 3;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_LCM = 3'd4;
  localparam logic [OP_W-1:0] OP_GCD = 3'd5;

endpackage

// ===== hdl/ialu_addsub.sv =====
// ----------------------------------------------------------------------------
// ialu_addsub
// Shared adder/subtractor with carry out; carry set on subtract means no borrow.
// ----------------------------------------------------------------------------
module ialu_addsub
  import ialu_pkg::*;
#(
  parameter int WIDTH = DATA_WIDTH_DEF + 1
) (
  input  logic [WIDTH-1:0] op_p,
  input  logic [WIDTH-1:0] op_q,
  input  logic             sub,
  output logic [WIDTH-1:0] sum,
  output logic             carry
);

  logic [WIDTH:0] full;

  assign full  = {1'b0, op_p} + {1'b0, op_q ^ {WIDTH{sub}}} + (WIDTH+1)'(sub);
  assign sum   = full[WIDTH-1:0];
  assign carry = full[WIDTH];

endmodule

// ===== hdl/integer_alu_gcd_lcm.sv =====
// ----------------------------------------------------------------------------
// integer_alu_gcd_lcm
// Add/sub: one adder pass; multiply: shift-add; divide: magnitudes, restoring
//   steps, negate on unlike signs; gcd: magnitudes, binary steps, shift back
//   twos; lcm: gcd, |a| / gcd, times |b|; unused codes, divide by zero and lcm
//   with a zero operand finish at once (strobe next cycle).
// Throughput: one item at a time, set by the single shared add/sub unit, which
//   takes one multiply, divide or gcd step per cycle.
// Reset: synchronous, active low; returns to idle, no result pending.
// ----------------------------------------------------------------------------
`include "integer_alu_gcd_lcm_macros.svh"

module integer_alu_gcd_lcm
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [OP_W-1:0]              in_op,
  input  logic signed [DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [DATA_WIDTH-1:0] in_operand_b,
  output logic                         out_strobe,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic                         out_error
);

  localparam int DW  = DATA_WIDTH;
  localparam int MSB = DW - 1;
  localparam int CW  = $clog2(DW);
  localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADDSUB = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_ABS_A  = 4'd3;
  localparam logic [3:0] S_ABS_B  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_NEG    = 4'd6;
  localparam logic [3:0] S_GCD    = 4'd7;
  localparam logic [3:0] S_GSHL   = 4'd8;

  logic [3:0]      state_r, state_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic [DW-1:0]   x_r, x_nxt;
  logic [DW-1:0]   y_r, y_nxt;
  logic [DW-1:0]   r_r, r_nxt;
  logic [DW-1:0]   ma_r, ma_nxt;
  logic [DW-1:0]   mb_r, mb_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic            neg_r, neg_nxt;
  logic            out_strobe_r;
  logic [DW-1:0]   out_value_r;
  logic            out_error_r;

  logic            fin;
  logic [DW-1:0]   fin_val;
  logic            fin_err;

  logic [DW:0]     u_p, u_q, u_sum;
  logic            u_sub, u_cout;

  logic [DW-1:0]   in_a, in_b;

  assign in_a = $unsigned(in_operand_a);
  assign in_b = $unsigned(in_operand_b);

  ialu_addsub #(
    .WIDTH (DW + 1)
  ) u_addsub (
    .op_p  (u_p),
    .op_q  (u_q),
    .sub   (u_sub),
    .sum   (u_sum),
    .carry (u_cout)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    r_nxt     = r_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    neg_nxt   = neg_r;
    u_p       = '0;
    u_q       = '0;
    u_sub     = 1'b0;
    fin       = 1'b0;
    fin_val   = '0;
    fin_err   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          x_nxt   = in_a;
          y_nxt   = in_b;
          op_nxt  = in_op;
          neg_nxt = in_a[MSB] ^ in_b[MSB];
          r_nxt   = '0;
          k_nxt   = '0;
          cnt_nxt = CNT_LAST;
          unique case (in_op)
            OP_ADD, OP_SUB: state_nxt = S_ADDSUB;
            OP_MUL:         state_nxt = S_MUL;
            OP_DIV: begin
              if (in_b == '0) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else begin
                state_nxt = S_ABS_A;
              end
            end
            OP_LCM: begin
              if (in_a == '0 || in_b == '0) begin
                fin = 1'b1;
              end else begin
                state_nxt = S_ABS_A;
              end
            end
            OP_GCD:  state_nxt = S_ABS_A;
            default: fin = 1'b1;
          endcase
        end
      end
      S_ADDSUB: begin
        u_p       = {1'b0, x_r};
        u_q       = {1'b0, y_r};
        u_sub     = (op_r == OP_SUB);
        fin       = 1'b1;
        fin_val   = u_sum[DW-1:0];
        state_nxt = S_IDLE;
      end
      S_MUL: begin
        // shift-add: accumulate the multiplicand on each set multiplier bit
        u_p = {1'b0, r_r};
        u_q = {1'b0, x_r};
        if (y_r[0]) begin
          r_nxt = u_sum[DW-1:0];
        end
        x_nxt   = {x_r[DW-2:0], 1'b0};
        y_nxt   = {1'b0, y_r[DW-1:1]};
        cnt_nxt = cnt_r - CNT_ONE;
        if (cnt_r == '0) begin
          fin       = 1'b1;
          fin_val   = r_nxt;
          state_nxt = S_IDLE;
        end
      end
      S_ABS_A: begin
        u_q       = {1'b0, x_r};
        u_sub     = 1'b1;
        ma_nxt    = x_r[MSB] ? u_sum[DW-1:0] : x_r;
        state_nxt = S_ABS_B;
      end
      S_ABS_B: begin
        u_q    = {1'b0, y_r};
        u_sub  = 1'b1;
        mb_nxt = y_r[MSB] ? u_sum[DW-1:0] : y_r;
        x_nxt  = ma_r;
        y_nxt  = mb_nxt;
        if (op_r == OP_DIV) begin
          r_nxt     = '0;
          cnt_nxt   = CNT_LAST;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_DIV: begin
        // restoring step: trial subtract of the divisor from the shifted remainder
        u_p   = {r_r, x_r[MSB]};
        u_q   = {1'b0, y_r};
        u_sub = 1'b1;
        if (u_cout) begin
          r_nxt = u_sum[DW-1:0];
          x_nxt = {x_r[DW-2:0], 1'b1};
        end else begin
          r_nxt = u_p[DW-1:0];
          x_nxt = {x_r[DW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_ONE;
        if (cnt_r == '0) begin
          if (op_r == OP_LCM) begin
            y_nxt     = mb_r;
            r_nxt     = '0;
            cnt_nxt   = CNT_LAST;
            state_nxt = S_MUL;
          end else if (neg_r) begin
            state_nxt = S_NEG;
          end else begin
            fin       = 1'b1;
            fin_val   = x_nxt;
            state_nxt = S_IDLE;
          end
        end
      end
      S_NEG: begin
        u_q       = {1'b0, x_r};
        u_sub     = 1'b1;
        fin       = 1'b1;
        fin_val   = u_sum[DW-1:0];
        state_nxt = S_IDLE;
      end
      S_GCD: begin
        u_p   = {1'b0, x_r};
        u_q   = {1'b0, y_r};
        u_sub = 1'b1;
        priority if (x_r == '0) begin
          state_nxt = S_GSHL;
        end else if (y_r == '0) begin
          y_nxt     = x_r;
          state_nxt = S_GSHL;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = {1'b0, x_r[DW-1:1]};
          y_nxt = {1'b0, y_r[DW-1:1]};
          k_nxt = k_r + CNT_ONE;
        end else if (!x_r[0]) begin
          x_nxt = {1'b0, x_r[DW-1:1]};
        end else if (!y_r[0]) begin
          y_nxt = {1'b0, y_r[DW-1:1]};
        end else if (u_cout) begin
          x_nxt = u_sum[DW-1:0];
        end else begin
          // smaller on top: swap and subtract next cycle
          x_nxt = y_r;
          y_nxt = x_r;
        end
      end
      S_GSHL: begin
        // restore the common power of two one bit per cycle
        if (k_r == '0) begin
          if (op_r == OP_GCD) begin
            fin       = 1'b1;
            fin_val   = y_r;
            state_nxt = S_IDLE;
          end else begin
            x_nxt     = ma_r;
            r_nxt     = '0;
            cnt_nxt   = CNT_LAST;
            state_nxt = S_DIV;
          end
        end else begin
          y_nxt = {y_r[DW-2:0], 1'b0};
          k_nxt = k_r - CNT_ONE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    r_r   <= r_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    cnt_r <= cnt_nxt;
    k_r   <= k_nxt;
    neg_r <= neg_nxt;
    if (fin) begin
      out_value_r <= fin_val;
      out_error_r <= fin_err;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_value  = $signed(out_value_r);
  assign out_error  = out_error_r;

  `IALU_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result strobe while busy")
  `IALU_ASSERT_NOW(a_strobe_cause, out_strobe, $past(busy) || $past(start), "result without an item")
  `IALU_ASSERT_NOW(a_err_zero, out_strobe && out_error, out_value == '0, "error with nonzero value")
  `IALU_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_strobe, "accepted item dropped")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_alu_gcd_lcm. A directed table covers the
// operand corners, every operation, division by zero, wrap cases and the
// unused codes; then random items run in phases of sender idling, each result
// being checked against an in-bench model of the arithmetic.
// ----------------------------------------------------------------------------
module tb;
  import ialu_pkg::*;

  localparam int DW        = DATA_WIDTH_DEF;
  localparam int NUM_DIR   = 26;
  localparam int RAND_ITEMS = 1125;
  localparam int NUM_PHASES = 4;
  localparam int SETTLE_CYCLES = 8 * DW;

  // codes the block treats as no operation
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] S_MAX = ~S_MIN;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 error;
  } alu_result_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic                 typed;
    logic signed [DW-1:0] value;
    logic                 error;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_op = '0;
  logic signed [DW-1:0] in_operand_a = '0;
  logic signed [DW-1:0] in_operand_b = '0;
  logic                 out_strobe;
  logic signed [DW-1:0] out_value;
  logic                 out_error;

  alu_result_t pending_results[$];
  int          mismatch_count = 0;

  integer_alu_gcd_lcm #(.DATA_WIDTH(DW)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_strobe   (out_strobe),
    .out_value    (out_value),
    .out_error    (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [DW-1:0] gcd_of(logic [DW-1:0] x, logic [DW-1:0] y);
    logic [DW-1:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic alu_result_t alu_predict(logic [OP_W-1:0] op,
                                              logic signed [DW-1:0] a,
                                              logic signed [DW-1:0] b);
    alu_result_t   r;
    logic [DW-1:0] ma, mb, q, g;
    r.value = '0;
    r.error = 1'b0;
    ma = a[DW-1] ? -a : a;
    mb = b[DW-1] ? -b : b;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_DIV: begin
        if (mb == 0) begin
          r.error = 1'b1;
        end else begin
          q = ma / mb;
          r.value = (a[DW-1] ^ b[DW-1]) ? -q : q;
        end
      end
      OP_LCM: begin
        if (ma != 0 && mb != 0) begin
          g = gcd_of(ma, mb);
          r.value = (ma / g) * mb;
        end
      end
      OP_GCD: r.value = gcd_of(ma, mb);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [DW-1:0] corner_operand();
    case ($urandom_range(0, 5))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return 1;
      4: return -1;
      default: return S_MIN + 1;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] rand_op();
    if ($urandom_range(0, 99) < 3)
      return $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
    return OP_W'($urandom_range(0, 5));
  endfunction

  task automatic rand_operands(output logic signed [DW-1:0] a,
                               output logic signed [DW-1:0] b);
    int k;
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        a = $urandom;
        b = $urandom;
      end
      3: begin
        a = int'($urandom_range(0, 400)) - 200;
        b = int'($urandom_range(0, 400)) - 200;
      end
      4: begin
        // share a factor so gcd and lcm are not trivially one
        k = $urandom_range(1, 4000);
        a = k * int'($urandom_range(0, 5000));
        b = k * int'($urandom_range(0, 5000));
      end
      5: begin
        a = corner_operand();
        b = $urandom_range(0, 1) ? corner_operand() : $urandom;
        if ($urandom_range(0, 1)) begin
          k = a;
          a = b;
          b = k;
        end
      end
      6: begin
        a = $urandom;
        b = int'($urandom_range(0, 20)) - 10;
      end
      default: begin
        a = 1 << $urandom_range(0, DW - 1);
        b = 1 << $urandom_range(0, DW - 1);
      end
    endcase
    if ($urandom_range(0, 3) == 0) a = -a;
    if ($urandom_range(0, 3) == 0) b = -b;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [OP_W-1:0] op, logic signed [DW-1:0] a,
                           logic signed [DW-1:0] b, alu_result_t expected);
    start        <= 1'b1;
    in_op        <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (busy);
    pending_results.push_back(expected);
    @(negedge clk);
  endtask

  // hold start low and wiggle the fields, which the block must ignore
  task automatic idle_for(int cycles);
    repeat (cycles) begin
      start        <= 1'b0;
      in_op        <= OP_W'($urandom);
      in_operand_a <= $urandom;
      in_operand_b <= $urandom;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: value %0d error %0b",
               out_value, out_error);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_value !== exp_r.value) begin
          $error("value: expected %0d, got %0d", exp_r.value, out_value);
          mismatch_count++;
        end
        if (out_error !== exp_r.error) begin
          $error("error: expected %0b, got %0b", exp_r.error, out_error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t            dir_rows [NUM_DIR];
    alu_result_t          exp_r;
    logic [OP_W-1:0]      op;
    logic signed [DW-1:0] a, b;
    int                   idle_pct [NUM_PHASES];
    int                   per_phase;

    dir_rows = '{
      '{OP_ADD, S_MAX, 1, 1'b1, S_MIN, 1'b0},
      '{OP_ADD, S_MIN, S_MIN, 1'b1, 0, 1'b0},
      '{OP_ADD, -1, 1, 1'b1, 0, 1'b0},
      '{OP_SUB, S_MIN, 1, 1'b1, S_MAX, 1'b0},
      '{OP_SUB, 0, S_MIN, 1'b1, S_MIN, 1'b0},
      '{OP_MUL, S_MAX, S_MAX, 1'b1, 1, 1'b0},
      '{OP_MUL, S_MIN, -1, 1'b1, S_MIN, 1'b0},
      '{OP_MUL, -3, 7, 1'b0, 0, 1'b0},
      '{OP_DIV, 7, 0, 1'b1, 0, 1'b1},
      '{OP_DIV, S_MIN, 0, 1'b1, 0, 1'b1},
      '{OP_DIV, S_MIN, -1, 1'b1, S_MIN, 1'b0},
      '{OP_DIV, -7, 2, 1'b1, -3, 1'b0},
      '{OP_DIV, S_MIN, S_MIN, 1'b1, 1, 1'b0},
      '{OP_DIV, 123456789, -1000, 1'b0, 0, 1'b0},
      '{OP_GCD, 0, 0, 1'b1, 0, 1'b0},
      '{OP_GCD, -12, 0, 1'b1, 12, 1'b0},
      '{OP_GCD, 0, S_MIN, 1'b1, S_MIN, 1'b0},
      '{OP_GCD, S_MIN, S_MIN, 1'b1, S_MIN, 1'b0},
      '{OP_GCD, 48, -36, 1'b0, 0, 1'b0},
      '{OP_GCD, S_MAX, S_MIN, 1'b0, 0, 1'b0},
      '{OP_LCM, 0, 5, 1'b1, 0, 1'b0},
      '{OP_LCM, S_MIN, 0, 1'b1, 0, 1'b0},
      '{OP_LCM, -4, 6, 1'b0, 0, 1'b0},
      '{OP_LCM, S_MAX, S_MIN, 1'b0, 0, 1'b0},
      '{OP_SPARE_LO, -1, -1, 1'b1, 0, 1'b0},
      '{OP_SPARE_HI, S_MAX, S_MIN, 1'b1, 0, 1'b0}
    };
    // the receiver cannot stall, so only the sender idles
    idle_pct  = '{0, 52, 0, 30};
    per_phase = RAND_ITEMS / NUM_PHASES;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        exp_r.value = dir_rows[i].value;
        exp_r.error = dir_rows[i].error;
      end else begin
        exp_r = alu_predict(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b);
      end
      send_item(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, exp_r);
    end
    idle_for(1);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int n = 0; n < per_phase; n++) begin
        op = rand_op();
        rand_operands(a, b);
        send_item(op, a, b, alu_predict(op, a, b));
        // gaps up to beyond one long operation land on every step of the work
        if (idle_pct[p] > 0 && $urandom_range(0, 99) < idle_pct[p])
          idle_for($urandom_range(1, 180));
      end
      idle_for(1);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== integer_alu_gcd_lcm.f =====
+incdir+hdl
hdl/ialu_pkg.sv
hdl/ialu_addsub.sv
hdl/integer_alu_gcd_lcm.sv
bench/tb.sv
